>>> rtl/core/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg: shared constants and a helper for the priority scheduler
// Thread count, mask widths, command codes and the mask bit helper.
// ----------------------------------------------------------------------------
package psd_pkg;

    // number of priority levels, idle included (range 2..32)
    localparam int THREADS = 32;
    // non-idle priorities, one mask bit and one delay counter each
    localparam int SLOTS   = THREADS - 1;
    localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PRIO_W  = 5;
    localparam int TICK_W  = 32;
    localparam int CMD_W   = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELAY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // mask bit of priority p (1..); zero for the idle priority
    function automatic logic [SLOTS-1:0] bit_for(input logic [PRIO_W-1:0] p);
        logic [SLOTS-1:0] m;
        m = '0;
        if (p != '0)
        begin
            m = SLOTS'(1) << (p - PRIO_W'(1));
        end
        return m;
    endfunction

endpackage

>>> rtl/core/psd_ram.sv
// ----------------------------------------------------------------------------
// psd_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module psd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 31
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/priority_scheduler_with_delays_core.sv
// ----------------------------------------------------------------------------
// priority_scheduler_with_delays_core: bitmask thread scheduler
// Ready/delayed/used masks in registers, per-priority delay counters in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall) carries one command item: cmd,
//   thread_prio (start) and delay_ticks (delay). Response channel
//   (rsp_valid/rsp_stall) returns one item per command: next_thread,
//   switch_request and error.
//   One item is in work at a time; req_stall is high while it is processed.
//   Start, delay and unknown commands pass through the exec and select steps
//   before the response is registered; no new item is taken until then.
//   A tick sweeps the delay counter RAM one entry per cycle, pipelined over
//   its registered read, from the top entry down to entry 0, then passes
//   through a last step before select; only then is the next item taken.
//   The sweep length is set by the single RAM read port.
//   A finished response sits in an output register; the next request is
//   accepted while it waits. If the receiver still stalls when the next
//   result is ready, the block holds in its select step until it is taken.
//   Reset clears masks, current thread and handshakes; only idle is used.
//   Delay counter contents are undefined after reset and are used only for
//   delayed threads, which always have a written counter.
// ----------------------------------------------------------------------------
module priority_scheduler_with_delays_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [psd_pkg::CMD_W-1:0]       cmd,
    input  logic [psd_pkg::PRIO_W-1:0]      thread_prio,
    input  logic [psd_pkg::TICK_W-1:0]      delay_ticks,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [psd_pkg::PRIO_W-1:0]      next_thread,
    output logic                            switch_request,
    output logic                            error
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK,
        ST_TICK_LAST,
        ST_SELECT
    } state_t;

    state_t                            state_reg;
    logic [psd_pkg::CMD_W-1:0]         cmd_reg;
    logic [psd_pkg::PRIO_W-1:0]        prio_reg;
    logic [psd_pkg::TICK_W-1:0]        ticks_reg;
    logic                              err_reg;
    logic [psd_pkg::SLOTS-1:0]         ready_reg;
    logic [psd_pkg::SLOTS-1:0]         delayed_reg;
    logic [psd_pkg::THREADS-1:0]       used_reg;
    logic [psd_pkg::PRIO_W-1:0]        current_reg;
    logic                              current_valid_reg;
    logic [psd_pkg::ADDR_W-1:0]        idx_reg;
    logic                              proc_valid_reg;
    logic [psd_pkg::ADDR_W-1:0]        proc_idx_reg;
    logic                              rsp_valid_reg;
    logic [psd_pkg::PRIO_W-1:0]        next_thread_reg;
    logic                              switch_reg;
    logic                              error_reg;

    logic                              ram_wr_en;
    logic [psd_pkg::ADDR_W-1:0]        ram_wr_addr;
    logic [psd_pkg::TICK_W-1:0]        ram_wr_data;
    logic                              ram_rd_en;
    logic [psd_pkg::TICK_W-1:0]        ram_rd_data;
    logic [psd_pkg::TICK_W-1:0]        dec_count;
    logic                              proc_hit;
    logic [psd_pkg::SLOTS-1:0]         proc_bit;
    logic [psd_pkg::PRIO_W-1:0]        sel_prio;
    logic                              start_ok;
    logic                              delay_ok;
    logic                              rsp_free;

    // delay counter store
    psd_ram #(
        .WIDTH (psd_pkg::TICK_W),
        .DEPTH (psd_pkg::SLOTS)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // command checks
    always_comb
    begin
        start_ok = ({1'b0, prio_reg} < (psd_pkg::PRIO_W + 1)'(psd_pkg::THREADS))
                   && ((used_reg & (psd_pkg::THREADS'(1) << prio_reg)) == '0);
        delay_ok = current_valid_reg && (current_reg != '0);
    end

    // tick sweep: decrement the entry read last cycle
    always_comb
    begin
        dec_count = ram_rd_data - psd_pkg::TICK_W'(1);
        proc_hit  = proc_valid_reg && delayed_reg[proc_idx_reg];
        proc_bit  = psd_pkg::SLOTS'(1) << proc_idx_reg;
        ram_rd_en = (state_reg == ST_TICK);
    end

    // RAM write port: delay command or tick write-back
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = proc_idx_reg;
        ram_wr_data = dec_count;
        if (proc_hit)
        begin
            ram_wr_en = 1'b1;
        end
        else if (state_reg == ST_EXEC && cmd_reg == psd_pkg::CMD_DELAY && delay_ok)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = psd_pkg::ADDR_W'(current_reg - psd_pkg::PRIO_W'(1));
            ram_wr_data = (ticks_reg == '0) ? psd_pkg::TICK_W'(1) : ticks_reg;
        end
    end

    // pick the highest ready priority
    always_comb
    begin
        sel_prio = '0;
        for (int i = 0; i < psd_pkg::SLOTS; i++)
        begin
            if (ready_reg[i])
            begin
                sel_prio = psd_pkg::PRIO_W'(i + 1);
            end
        end
    end

    assign rsp_free       = !rsp_valid_reg || !rsp_stall;
    assign req_stall      = (state_reg != ST_IDLE);
    assign rsp_valid      = rsp_valid_reg;
    assign next_thread    = next_thread_reg;
    assign switch_request = switch_reg;
    assign error          = error_reg;

    // control sequencer, masks and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cmd_reg           <= psd_pkg::CMD_START;
            prio_reg          <= '0;
            ticks_reg         <= '0;
            ready_reg         <= '0;
            delayed_reg       <= '0;
            used_reg          <= psd_pkg::THREADS'(1);
            current_reg       <= '0;
            current_valid_reg <= 1'b0;
            proc_valid_reg    <= 1'b0;
            proc_idx_reg      <= '0;
            rsp_valid_reg     <= 1'b0;
            next_thread_reg   <= '0;
            switch_reg        <= 1'b0;
            error_reg         <= 1'b0;
            idx_reg           <= '0;
            err_reg           <= 1'b0;
        end
        else
        begin
            // drop a taken response
            if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            // apply the tick write-back to the masks
            proc_valid_reg <= 1'b0;
            if (proc_hit && dec_count == '0)
            begin
                ready_reg   <= ready_reg | proc_bit;
                delayed_reg <= delayed_reg & ~proc_bit;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        cmd_reg   <= cmd;
                        prio_reg  <= thread_prio;
                        ticks_reg <= delay_ticks;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    err_reg   <= 1'b0;
                    state_reg <= ST_SELECT;
                    case (cmd_reg)
                        psd_pkg::CMD_START:
                        begin
                            if (start_ok)
                            begin
                                used_reg  <= used_reg | (psd_pkg::THREADS'(1) << prio_reg);
                                ready_reg <= ready_reg | psd_pkg::bit_for(prio_reg);
                            end
                            else
                            begin
                                err_reg <= 1'b1;
                            end
                        end
                        psd_pkg::CMD_DELAY:
                        begin
                            if (delay_ok)
                            begin
                                ready_reg   <= ready_reg & ~psd_pkg::bit_for(current_reg);
                                delayed_reg <= delayed_reg | psd_pkg::bit_for(current_reg);
                            end
                            else
                            begin
                                err_reg <= 1'b1;
                            end
                        end
                        psd_pkg::CMD_TICK:
                        begin
                            idx_reg   <= psd_pkg::ADDR_W'(psd_pkg::SLOTS - 1);
                            state_reg <= ST_TICK;
                        end
                        default:
                        begin
                            state_reg <= ST_SELECT;
                        end
                    endcase
                end
                ST_TICK:
                begin
                    // read one counter, process it next cycle
                    proc_valid_reg <= 1'b1;
                    proc_idx_reg   <= idx_reg;
                    if (idx_reg == '0)
                    begin
                        state_reg <= ST_TICK_LAST;
                    end
                    else
                    begin
                        idx_reg <= idx_reg - psd_pkg::ADDR_W'(1);
                    end
                end
                ST_TICK_LAST:
                begin
                    state_reg <= ST_SELECT;
                end
                ST_SELECT:
                begin
                    // hold until the response register is free
                    if (rsp_free)
                    begin
                        rsp_valid_reg     <= 1'b1;
                        next_thread_reg   <= sel_prio;
                        switch_reg        <= !current_valid_reg || (sel_prio != current_reg);
                        error_reg         <= err_reg;
                        current_reg       <= sel_prio;
                        current_valid_reg <= 1'b1;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // a thread is never ready and delayed at once
    a_ready_delayed_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (ready_reg & delayed_reg) == '0)
        else $error("thread both ready and delayed");

    // counter writes stay inside the store
    a_wr_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> ({1'b0, ram_wr_addr} < (psd_pkg::ADDR_W + 1)'(psd_pkg::SLOTS)))
        else $error("counter write out of range");

    // a selected thread has been started
    a_next_used: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ((used_reg & (psd_pkg::THREADS'(1) << next_thread_reg)) != '0))
        else $error("selected thread never started");

    // every delayed thread has been started
    a_delayed_used: assert property (@(posedge clk) disable iff (!rst_n)
        (delayed_reg & ~used_reg[psd_pkg::THREADS-1:1]) == '0)
        else $error("delayed thread not started");

endmodule
